FILE: sv/cu_pkg.sv
// Shared types and constants for the combination unranker.
package cu_pkg;

  localparam int unsigned SetSizeW  = 11;
  localparam int unsigned SubsetW   = 2;
  localparam int unsigned RankW     = 28;
  localparam int unsigned IdxW      = 10;
  localparam int unsigned CfgIndexW = 2;
  localparam int unsigned MulW      = 32;
  localparam int unsigned Pair2W    = 19;

  localparam logic [SetSizeW-1:0] MaxSetSize       = 11'd1024;
  localparam logic [SetSizeW-1:0] SetSizeReset     = 11'd16;
  localparam logic [SubsetW-1:0]  SubsetSizeReset  = 2'd3;
  localparam logic [MulW-1:0]     InverseOfThree   = 32'hAAAA_AAAB;

  localparam logic [CfgIndexW-1:0] CfgSetSize    = 2'd0;
  localparam logic [CfgIndexW-1:0] CfgSubsetSize = 2'd1;

  localparam logic [SubsetW-1:0] PickOne = 2'd1;
  localparam logic [SubsetW-1:0] PickTwo = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_CHECK,
    ST_SEARCH
  } cu_state_e;

endpackage

FILE: sv/combination_unranker_top.sv
// Combination unranker: one shared multiplier for setup, then a one-candidate-per-cycle search.
// Setup is three multiplier passes and a range check, followed by the candidate search.
// Throughput: one rank at a time; busy_o stays high until the last result is strobed.
// Results are strobed for one cycle each and cannot be stalled by the receiver.
// Reset is asynchronous and active low; it restores set_size = 16 and subset_size = 3.
module combination_unranker_top
  import cu_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [SetSizeW-1:0]  cfg_data_i,
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic [RankW-1:0]     rank_i,
  output logic                 result_valid_o,
  output logic [IdxW-1:0]      element_index_o,
  output logic                 last_o,
  output logic                 range_error_o
);

  cu_state_e state_q, state_d;

  logic [SetSizeW-1:0] set_size_q;
  logic [SubsetW-1:0]  subset_size_q;

  logic [RankW-1:0]    rank_q, rank_d;
  logic [RankW-1:0]    x_q, x_d;
  logic [SetSizeW-1:0] a_q, a_d;
  logic [SubsetW-1:0]  b_q, b_d;
  logic [MulW-1:0]     m_q, m_d;
  logic [Pair2W-1:0]   c2_q, c2_d;
  logic [RankW-1:0]    c3_q, c3_d;

  logic                res_valid_q, res_valid_d;
  logic [IdxW-1:0]     res_idx_q, res_idx_d;
  logic                res_last_q, res_last_d;
  logic                res_err_q, res_err_d;

  logic [MulW-1:0]     mul_a, mul_b;
  logic [MulW-1:0]     mul_full;
  logic [SetSizeW-1:0] a_m1;
  logic [Pair2W-1:0]   c2_dec;
  logic [RankW-1:0]    c3_dec;
  logic [RankW-1:0]    c_sel;
  logic [SetSizeW-1:0] emit_idx;
  logic                bad_cfg;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_size_q    <= SetSizeReset;
      subset_size_q <= SubsetSizeReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CfgSetSize:    set_size_q    <= cfg_data_i;
        CfgSubsetSize: subset_size_q <= cfg_data_i[SubsetW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (state_q)
      ST_MUL1: begin
        mul_a = MulW'(set_size_q);
        mul_b = MulW'(set_size_q - 11'd1);
      end
      ST_MUL2: begin
        mul_a = m_q;
        mul_b = MulW'(set_size_q - 11'd2);
      end
      ST_MUL3: begin
        mul_a = m_q >> 1;
        mul_b = InverseOfThree;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_full = mul_a * mul_b;

  assign a_m1     = a_q - 11'd1;
  assign c2_dec   = c2_q - Pair2W'(a_m1);
  assign c3_dec   = c3_q - RankW'(c2_dec);
  assign emit_idx = set_size_q - 11'd1 - a_q;
  assign bad_cfg  = (subset_size_q == '0) || (SetSizeW'(subset_size_q) > set_size_q) ||
                    (set_size_q > MaxSetSize);

  always_comb begin
    case (b_q)
      PickOne: c_sel = RankW'(a_q);
      PickTwo: c_sel = RankW'(c2_q);
      default: c_sel = c3_q;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    rank_d      = rank_q;
    x_d         = x_q;
    a_d         = a_q;
    b_d         = b_q;
    m_d         = m_q;
    c2_d        = c2_q;
    c3_d        = c3_q;
    res_valid_d = 1'b0;
    res_idx_d   = res_idx_q;
    res_last_d  = res_last_q;
    res_err_d   = res_err_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          rank_d  = rank_i;
          a_d     = set_size_q;
          b_d     = subset_size_q;
          state_d = ST_MUL1;
        end
      end
      ST_MUL1: begin
        m_d     = mul_full[MulW-1:0];
        state_d = ST_MUL2;
      end
      ST_MUL2: begin
        c2_d    = m_q[Pair2W:1];
        m_d     = mul_full[MulW-1:0];
        state_d = ST_MUL3;
      end
      ST_MUL3: begin
        c3_d    = mul_full[RankW-1:0];
        state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (bad_cfg || (rank_q >= c_sel)) begin
          res_valid_d = 1'b1;
          res_idx_d   = '0;
          res_last_d  = 1'b1;
          res_err_d   = 1'b1;
          state_d     = ST_IDLE;
        end else begin
          x_d     = c_sel - RankW'(1) - rank_q;
          a_d     = a_m1;
          c2_d    = c2_dec;
          c3_d    = c3_dec;
          state_d = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        a_d  = a_m1;
        c2_d = c2_dec;
        c3_d = c3_dec;
        if (c_sel <= x_q) begin
          res_valid_d = 1'b1;
          res_idx_d   = emit_idx[IdxW-1:0];
          res_last_d  = (b_q == PickOne);
          res_err_d   = 1'b0;
          x_d         = x_q - c_sel;
          b_d         = b_q - 2'd1;
          if (b_q == PickOne) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rank_q    <= rank_d;
    x_q       <= x_d;
    a_q       <= a_d;
    b_q       <= b_d;
    m_q       <= m_d;
    c2_q      <= c2_d;
    c3_q      <= c3_d;
    res_idx_q <= res_idx_d;
    res_last_q <= res_last_d;
    res_err_q <= res_err_d;
  end

  assign busy_o          = (state_q != ST_IDLE);
  assign result_valid_o  = res_valid_q;
  assign element_index_o = res_idx_q;
  assign last_o          = res_last_q;
  assign range_error_o   = res_err_q;

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("accepted rank did not make the block busy");

  a_error_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && range_error_o |-> last_o && (element_index_o == '0))
    else $error("error result is not a single marked zero element");

  a_more_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_o |-> busy_o && (state_q == ST_SEARCH))
    else $error("non-final element strobed while the search is over");

  a_search_pick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SEARCH |-> b_q != '0)
    else $error("search running with no element left to pick");

endmodule

FILE: verif/tb.sv
// Self-checking testbench for the combination unranker: directed table, then randomized phases.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cu_pkg::*;

  localparam int unsigned ClkPeriod   = 12;
  localparam int unsigned ResetCycles = 7;
  localparam int unsigned QuietLimit  = 20000;
  localparam int unsigned DrainCycles = 1100;
  localparam int unsigned RandomItems = 105;
  localparam int unsigned NumDirected = 25;

  localparam logic [CfgIndexW-1:0] CfgSpareLow  = 2'd2;
  localparam logic [CfgIndexW-1:0] CfgSpareHigh = 2'd3;

  typedef struct packed {
    logic [IdxW-1:0] index;
    logic            last;
    logic            err;
  } element_t;

  typedef struct packed {
    logic [SetSizeW-1:0] n;
    logic [SubsetW-1:0]  r;
    logic [RankW-1:0]    rank;
    logic                typed;
    logic                err;
    logic [IdxW-1:0]     e0;
    logic [IdxW-1:0]     e1;
    logic [IdxW-1:0]     e2;
  } directed_row_t;

  localparam directed_row_t DirectedRows [NumDirected] = '{
    '{11'd16,   2'd3, 28'd0,         1'b1, 1'b0, 10'd0,    10'd1,    10'd2},
    '{11'd16,   2'd3, 28'd559,       1'b1, 1'b0, 10'd13,   10'd14,   10'd15},
    '{11'd16,   2'd3, 28'd560,       1'b1, 1'b1, 10'd0,    10'd0,    10'd0},
    '{11'd16,   2'd3, 28'hFFFFFFF,   1'b1, 1'b1, 10'd0,    10'd0,    10'd0},
    '{11'd16,   2'd3, 28'd1,         1'b0, 1'b0, 10'd0,    10'd0,    10'd0},
    '{11'd1,    2'd1, 28'd0,         1'b1, 1'b0, 10'd0,    10'd0,    10'd0},
    '{11'd1,    2'd1, 28'd1,         1'b1, 1'b1, 10'd0,    10'd0,    10'd0},
    '{11'd1,    2'd2, 28'd0,         1'b1, 1'b1, 10'd0,    10'd0,    10'd0},
    '{11'd1024, 2'd3, 28'd0,         1'b1, 1'b0, 10'd0,    10'd1,    10'd2},
    '{11'd1024, 2'd3, 28'd178433023, 1'b1, 1'b0, 10'd1021, 10'd1022, 10'd1023},
    '{11'd1024, 2'd3, 28'd178433024, 1'b1, 1'b1, 10'd0,    10'd0,    10'd0},
    '{11'd1024, 2'd1, 28'd1023,      1'b1, 1'b0, 10'd1023, 10'd0,    10'd0},
    '{11'd1024, 2'd1, 28'd0,         1'b1, 1'b0, 10'd0,    10'd0,    10'd0},
    '{11'd1024, 2'd2, 28'd523775,    1'b1, 1'b0, 10'd1022, 10'd1023, 10'd0},
    '{11'd1024, 2'd2, 28'd200000,    1'b0, 1'b0, 10'd0,    10'd0,    10'd0},
    '{11'd1025, 2'd1, 28'd0,         1'b1, 1'b1, 10'd0,    10'd0,    10'd0},
    '{11'd2047, 2'd3, 28'd0,         1'b1, 1'b1, 10'd0,    10'd0,    10'd0},
    '{11'd0,    2'd1, 28'd0,         1'b1, 1'b1, 10'd0,    10'd0,    10'd0},
    '{11'd4,    2'd0, 28'd0,         1'b1, 1'b1, 10'd0,    10'd0,    10'd0},
    '{11'd4,    2'd2, 28'd1,         1'b0, 1'b0, 10'd0,    10'd0,    10'd0},
    '{11'd3,    2'd3, 28'd0,         1'b1, 1'b0, 10'd0,    10'd1,    10'd2},
    '{11'd3,    2'd3, 28'd1,         1'b1, 1'b1, 10'd0,    10'd0,    10'd0},
    '{11'd5,    2'd2, 28'd9,         1'b1, 1'b0, 10'd3,    10'd4,    10'd0},
    '{11'd7,    2'd3, 28'd17,        1'b0, 1'b0, 10'd0,    10'd0,    10'd0},
    '{11'd1024, 2'd3, 28'd100000000, 1'b0, 1'b0, 10'd0,    10'd0,    10'd0}
  };

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CfgIndexW-1:0] cfg_index_i;
  logic [SetSizeW-1:0]  cfg_data_i;
  logic                 start_i;
  logic                 busy_o;
  logic [RankW-1:0]     rank_i;
  logic                 result_valid_o;
  logic [IdxW-1:0]      element_index_o;
  logic                 last_o;
  logic                 range_error_o;

  logic [SetSizeW-1:0] model_n;
  logic [SubsetW-1:0]  model_r;
  element_t            expected_elements [$];
  int unsigned         fail_count   = 0;
  int unsigned         quiet_cycles = 0;

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  combination_unranker_top u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .rank_i          (rank_i),
    .result_valid_o  (result_valid_o),
    .element_index_o (element_index_o),
    .last_o          (last_o),
    .range_error_o   (range_error_o)
  );

  function automatic longint unsigned binomial(input longint top, input longint pick);
    if (top < 0 || pick < 0 || pick > top) begin
      return 0;
    end
    case (pick)
      0:       return 1;
      1:       return top;
      2:       return top * (top - 1) / 2;
      default: return top * (top - 1) * (top - 2) / 6;
    endcase
  endfunction

  task automatic unrank_expected(input logic [RankW-1:0] rank);
    longint            n;
    longint            r;
    longint            a;
    longint            b;
    longint unsigned   total;
    longint unsigned   remaining;
    element_t          elem;
    n = longint'(model_n);
    r = longint'(model_r);
    total = binomial(n, r);
    if (r == 0 || r > n || n > longint'(MaxSetSize) || longint'(rank) >= total) begin
      elem = '{index: '0, last: 1'b1, err: 1'b1};
      expected_elements = {expected_elements, elem};
    end else begin
      remaining = total - 1 - longint'(rank);
      a = n;
      b = r;
      for (longint i = 0; i < r; i++) begin
        a--;
        while (a >= 0 && binomial(a, b) > remaining) begin
          a--;
        end
        elem = '{index: IdxW'(n - 1 - a), last: (i == r - 1), err: 1'b0};
        expected_elements = {expected_elements, elem};
        remaining -= binomial(a, b);
        b--;
      end
    end
  endtask

  task automatic write_register(input logic [CfgIndexW-1:0] index,
                                input logic [SetSizeW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (index == CfgSetSize) begin
      model_n = data;
    end else if (index == CfgSubsetSize) begin
      model_r = data[SubsetW-1:0];
    end
    @(negedge clk_i);
  endtask

  task automatic configure(input logic [SetSizeW-1:0] n_data,
                           input logic [SetSizeW-1:0] r_data, input bit spare);
    if (spare) begin
      write_register(($urandom_range(0, 1) == 0) ? CfgSpareLow : CfgSpareHigh,
                     SetSizeW'($urandom));
    end
    write_register(CfgSetSize, n_data);
    write_register(CfgSubsetSize, r_data);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_rank(input logic [RankW-1:0] rank);
    start_i <= 1'b1;
    rank_i  <= rank;
    do @(posedge clk_i); while (busy_o);
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    start_i <= 1'b0;
    @(negedge clk_i);
    while (expected_elements.size() != 0 || busy_o) begin
      @(negedge clk_i);
    end
  endtask

  always @(posedge clk_i) begin : check_result
    element_t exp_elem;
    if (rst_ni && result_valid_o) begin
      if (expected_elements.size() == 0) begin
        $display("%0t ns: unexpected result, expected none, actual index %0d last %0b error %0b",
                 $time, element_index_o, last_o, range_error_o);
        fail_count++;
      end else begin
        exp_elem = expected_elements.pop_front();
        if (element_index_o !== exp_elem.index) begin
          $display("%0t ns: element_index expected %0d actual %0d",
                   $time, exp_elem.index, element_index_o);
          fail_count++;
        end
        if (last_o !== exp_elem.last) begin
          $display("%0t ns: last expected %0b actual %0b", $time, exp_elem.last, last_o);
          fail_count++;
        end
        if (range_error_o !== exp_elem.err) begin
          $display("%0t ns: range_error expected %0b actual %0b",
                   $time, exp_elem.err, range_error_o);
          fail_count++;
        end
      end
    end
  end

  initial begin : watchdog
    while (quiet_cycles < QuietLimit) begin
      @(posedge clk_i);
      if (!rst_ni || (start_i && !busy_o) || (cfg_valid_i && cfg_ready_o) || result_valid_o) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("%0t ns: timeout, no transfer for %0d cycles", $time, QuietLimit);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    directed_row_t                  row;
    element_t                       elem;
    logic [SetSizeW-1:0]            n_sel;
    logic [SubsetW-1:0]             r_sel;
    logic [SetSizeW-SubsetW-1:0]    pad;
    logic [RankW-1:0]               rank_sel;
    longint unsigned                total;
    int unsigned                    idle_pct;
    int unsigned                    phase_items;
    int unsigned                    sent;
    int unsigned                    phase;
    int unsigned                    pick;
    rst_ni      <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= CfgSetSize;
    cfg_data_i  <= '0;
    start_i     <= 1'b0;
    rank_i      <= '0;
    model_n = SetSizeReset;
    model_r = SubsetSizeReset;
    repeat (ResetCycles) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < NumDirected; i++) begin
      row = DirectedRows[i];
      if (row.n != model_n || row.r != model_r) begin
        wait_idle();
        configure(row.n, SetSizeW'(row.r), 1'b0);
      end
      send_rank(row.rank);
      if (!row.typed) begin
        unrank_expected(row.rank);
      end else if (row.err) begin
        elem = '{index: '0, last: 1'b1, err: 1'b1};
        expected_elements = {expected_elements, elem};
      end else begin
        for (int k = 0; k < row.r; k++) begin
          elem = '{index: (k == 0) ? row.e0 : (k == 1) ? row.e1 : row.e2,
                   last: (k == row.r - 1), err: 1'b0};
          expected_elements = {expected_elements, elem};
        end
      end
    end

    sent  = 0;
    phase = 0;
    while (sent < RandomItems) begin
      idle_pct = (phase % 3 == 0) ? 0 : (phase % 3 == 1) ? 49 : 12;
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        n_sel = SetSizeW'($urandom_range(1, 40));
      end else if (pick < 80) begin
        n_sel = SetSizeW'($urandom_range(41, 1023));
      end else if (pick < 88) begin
        n_sel = MaxSetSize;
      end else if (pick < 94) begin
        n_sel = '0;
      end else begin
        n_sel = SetSizeW'($urandom_range(1025, 2047));
      end
      r_sel = ($urandom_range(0, 99) < 88) ? SubsetW'($urandom_range(1, 3)) : '0;
      pad   = (SetSizeW-SubsetW)'($urandom);
      wait_idle();
      configure(n_sel, {pad, r_sel}, $urandom_range(0, 3) == 0);
      phase_items = (n_sel > 100) ? 2 : 10;
      repeat (phase_items) begin
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
          start_i <= 1'b0;
          repeat ($urandom_range(1, 20)) @(negedge clk_i);
        end
        total = binomial(longint'(model_n), longint'(model_r));
        pick  = $urandom_range(0, 99);
        if (total != 0 && pick < 75) begin
          rank_sel = RankW'($urandom % total);
        end else if (total != 0 && pick < 85) begin
          rank_sel = RankW'(total);
        end else if (total != 0 && pick < 90) begin
          rank_sel = RankW'(total - 1);
        end else begin
          rank_sel = RankW'($urandom);
        end
        send_rank(rank_sel);
        unrank_expected(rank_sel);
        sent++;
      end
      phase++;
    end

    wait_idle();
    repeat (DrainCycles) @(negedge clk_i);
    if (fail_count == 0 && expected_elements.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
